[rtl/core/pfb_pkg.sv]
package pfb_pkg;

  // screen defaults
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  // rows per page, and the all-ones byte
  localparam int         PAGE_ROWS = 8;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // most run descriptors sent by one flush
  localparam int RUN_LIMIT = 4;

  // command codes
  localparam logic [2:0] CMD_PIXEL = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_FLUSH = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // result kinds
  localparam logic OUT_KIND_READ = 1'b0;
  localparam logic OUT_KIND_RUN  = 1'b1;

  // stream widths
  localparam int S_DATA_W = 48;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 16;
  localparam int M_USER_W = 1;

endpackage

[rtl/core/pfb_ram.sv]
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/paged_framebuffer_dirty_flush.sv]
// paged monochrome framebuffer with per-page dirty bits
//
// commands come in on the s_axis channel, results leave on m_axis; a one-entry
// output register parts the two, so a new command is taken while a result waits.
// the block works on one command at a time and drops s_axis_tready meanwhile.
// steps per command:
//   pixel: decode, then one read and one write of the page byte
//   fill: decode, then each page byte inside the clipped rectangle (one ram port pair,
//     read then write back per byte)
//   clear: ram sweep of 2**(clog2(pages) + clog2(SCREEN_WIDTH)) addresses
//   flush: scans the pages in order, up to pages + 1 scan steps, plus output stalls
//   read: the page byte is read, then loaded into the output register
// a result is held until m_axis_tready; while the output register is full the
// sequencer waits at the point where it would load the next one.
// reset clears the dirty bits and the blanking register, then sweeps zeros into
// the whole store (1024 bytes at the default size) with s_axis_tready low.
// the blanking register is written on the cfg channel at any time; cfg_ready is
// always high.
module paged_framebuffer_dirty_flush #(
  parameter int SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_x[8:0], pos_y[16:9], rect_width[24:17], rect_height[31:25],
  // set_pixel[32], read_page[35:33], read_column[42:36], zero pad
  input  logic [pfb_pkg::S_DATA_W-1:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [pfb_pkg::S_USER_W-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // read_byte[7:0], run_start_page[10:8], run_pages[14:11], zero pad
  output logic [pfb_pkg::M_DATA_W-1:0] m_axis_tdata,
  // out_kind[0]
  output logic [pfb_pkg::M_USER_W-1:0] m_axis_tuser,
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);

  localparam int NUM_PAGES = (SCREEN_HEIGHT + pfb_pkg::PAGE_ROWS - 1) / pfb_pkg::PAGE_ROWS;
  localparam int PAGE_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int COL_W     = $clog2(SCREEN_WIDTH);
  localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
  localparam int ADDR_W    = PAGE_W + COL_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int RUN_CNT_W = $clog2(pfb_pkg::RUN_LIMIT);

  localparam logic signed [9:0] W_S = 10'(SCREEN_WIDTH);
  localparam logic signed [8:0] H_S = 9'(SCREEN_HEIGHT);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_RD     = 3'd3;
  localparam logic [2:0] ST_WR     = 3'd4;
  localparam logic [2:0] ST_RDRES  = 3'd5;
  localparam logic [2:0] ST_FLUSH  = 3'd6;

  function automatic logic [PAGE_W-1:0] page_of(input logic [ROW_W-1:0] row);
    page_of = PAGE_W'(row >> 3);
  endfunction

  logic [2:0] state;
  logic       blanked;
  logic [NUM_PAGES-1:0] dirty;
  logic [ADDR_W-1:0]    clr_addr;

  // captured command
  logic [2:0] cmd_q;
  logic [8:0] pos_x_q;
  logic [7:0] pos_y_q;
  logic [7:0] rect_width_q;
  logic [6:0] rect_height_q;
  logic       set_q;
  logic [2:0] read_page_q;
  logic [6:0] read_column_q;

  // walk registers
  logic [COL_W-1:0]  col, x0r, x1m;
  logic [ROW_W-1:0]  y0r, y1m;
  logic [PAGE_W-1:0] pg;
  logic              rd_ok;

  // flush scan
  logic [PAGE_W:0]    fp, rs;
  logic               in_run;
  logic [RUN_CNT_W-1:0] nrun;

  // output register
  logic       o_valid, o_kind, o_last;
  logic [7:0] o_byte;
  logic [2:0] o_start;
  logic [3:0] o_pages;
  logic       out_load;
  logic       out_set;

  // ram
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // clipping
  logic signed [9:0] xs, w_ext, xe, x0, x1;
  logic signed [8:0] ys, h_ext, ye, y0, y1;
  logic              clip_ok;

  // byte mask and scan helpers
  logic [2:0] lo, hi;
  logic [7:0] mask;
  logic       at_end, cur_dirty, more, run_last;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_load      = !o_valid || m_axis_tready;

  // a result is loaded into the output register this cycle
  assign out_set = out_load &&
                   ((state == ST_RDRES) || (state == ST_FLUSH && !cur_dirty && in_run));

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {1'b0, o_pages, o_start, o_byte};
  assign m_axis_tuser  = o_kind;
  assign m_axis_tlast  = o_last;

  always_comb begin
    xs    = {pos_x_q[8], pos_x_q};
    w_ext = (cmd_q == pfb_pkg::CMD_PIXEL) ? 10'sd1 : {2'b00, rect_width_q};
    xe    = xs + w_ext;
    x0    = xs[9] ? 10'sd0 : xs;
    x1    = (xe > W_S) ? W_S : xe;
    ys    = {pos_y_q[7], pos_y_q};
    h_ext = (cmd_q == pfb_pkg::CMD_PIXEL) ? 9'sd1 : {2'b00, rect_height_q};
    ye    = ys + h_ext;
    y0    = ys[8] ? 9'sd0 : ys;
    y1    = (ye > H_S) ? H_S : ye;
    clip_ok = (x0 < x1) && (y0 < y1);
  end

  always_comb begin
    lo   = (pg == page_of(y0r)) ? y0r[2:0] : 3'd0;
    hi   = (pg == page_of(y1m)) ? y1m[2:0] : 3'd7;
    mask = (pfb_pkg::BYTE_ONES << lo) & (pfb_pkg::BYTE_ONES >> (3'd7 - hi));
  end

  always_comb begin
    at_end    = (fp == (PAGE_W + 1)'(NUM_PAGES));
    cur_dirty = !at_end && dirty[fp[PAGE_W-1:0]];
    more      = (dirty >> fp) != '0;
    run_last  = (nrun == RUN_CNT_W'(pfb_pkg::RUN_LIMIT - 1)) || !more;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {pg, col};
    ram_wdata = set_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
    ram_re    = (state == ST_RD);
    if (state == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_WR) begin
      ram_we = 1'b1;
    end
  end

  pfb_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr({pg, col}),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      blanked  <= 1'b0;
      dirty    <= '0;
      clr_addr <= '0;
      o_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        blanked <= cfg_data;
      end
      if (out_set) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end

      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q         <= s_axis_tuser;
            pos_x_q       <= s_axis_tdata[8:0];
            pos_y_q       <= s_axis_tdata[16:9];
            rect_width_q  <= s_axis_tdata[24:17];
            rect_height_q <= s_axis_tdata[31:25];
            set_q         <= s_axis_tdata[32];
            read_page_q   <= s_axis_tdata[35:33];
            read_column_q <= s_axis_tdata[42:36];
            state         <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (cmd_q)
            pfb_pkg::CMD_PIXEL, pfb_pkg::CMD_FILL: begin
              x0r <= COL_W'(x0);
              x1m <= COL_W'(x1 - 10'sd1);
              y0r <= ROW_W'(y0);
              y1m <= ROW_W'(y1 - 9'sd1);
              col <= COL_W'(x0);
              pg  <= page_of(ROW_W'(y0));
              state <= clip_ok ? ST_RD : ST_IDLE;
            end
            pfb_pkg::CMD_CLEAR: begin
              dirty    <= '1;
              clr_addr <= '0;
              state    <= ST_CLR;
            end
            pfb_pkg::CMD_FLUSH: begin
              fp     <= '0;
              in_run <= 1'b0;
              nrun   <= '0;
              state  <= (blanked || dirty == '0) ? ST_IDLE : ST_FLUSH;
            end
            pfb_pkg::CMD_READ: begin
              pg    <= PAGE_W'(read_page_q);
              col   <= COL_W'(read_column_q);
              rd_ok <= (int'(read_page_q) < NUM_PAGES) &&
                       (int'(read_column_q) < SCREEN_WIDTH);
              state <= ST_RD;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_RD: begin
          state <= (cmd_q == pfb_pkg::CMD_READ) ? ST_RDRES : ST_WR;
        end
        ST_WR: begin
          dirty[pg] <= 1'b1;
          if (col == x1m) begin
            col <= x0r;
            if (pg == page_of(y1m)) begin
              state <= ST_IDLE;
            end else begin
              pg    <= pg + 1'b1;
              state <= ST_RD;
            end
          end else begin
            col   <= col + 1'b1;
            state <= ST_RD;
          end
        end
        ST_RDRES: begin
          if (out_load) begin
            o_kind  <= pfb_pkg::OUT_KIND_READ;
            o_byte  <= rd_ok ? ram_rdata : 8'd0;
            o_start <= 3'd0;
            o_pages <= 4'd0;
            o_last  <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (cur_dirty) begin
            // page joins the current run or opens a new one
            dirty[fp[PAGE_W-1:0]] <= 1'b0;
            if (!in_run) begin
              rs     <= fp;
              in_run <= 1'b1;
            end
            fp <= fp + 1'b1;
          end else if (in_run) begin
            // run ends here: hand it out when the output register is free
            if (out_load) begin
              o_kind  <= pfb_pkg::OUT_KIND_RUN;
              o_byte  <= 8'd0;
              o_start <= 3'(rs);
              o_pages <= 4'(fp - rs);
              o_last  <= run_last;
              in_run  <= 1'b0;
              nrun    <= nrun + 1'b1;
              if (run_last) begin
                state <= ST_IDLE;
              end else begin
                fp <= fp + 1'b1;
              end
            end
          end else if (at_end) begin
            state <= ST_IDLE;
          end else begin
            fp <= fp + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/pfb_checker.sv]
module pfb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pfb_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [pfb_pkg::M_USER_W-1:0] m_axis_tuser,
  input logic                         m_axis_tlast
);

  // reset empties the output register and starts the store sweep
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("output valid or input ready right after reset");

  // one command at a time: ready drops after each transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an input transfer");

  // a read result is always the only and final result of its command
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == pfb_pkg::OUT_KIND_READ |-> m_axis_tlast)
    else $error("read result without tlast");

  // a run descriptor covers at least one page and carries no byte
  a_run_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == pfb_pkg::OUT_KIND_RUN |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[14:11] != 4'd0)
    else $error("malformed run descriptor");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind paged_framebuffer_dirty_flush pfb_checker u_pfb_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

[tb/paged_framebuffer_dirty_flush_tb.sv]
`timescale 1ns / 100ps

module paged_framebuffer_dirty_flush_tb;
  import pfb_pkg::*;

  localparam int NUM_PAGES     = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES   = SCREEN_WIDTH * NUM_PAGES;
  localparam int SETTLE_CYCLES = 2100;   // outlasts a full-screen fill
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [2:0] CMD_MAX_CODE = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [6:0] h;
    logic       on;
    logic [2:0] rpage;
    logic [6:0] rcol;
  } fb_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [2:0] start;
    logic [3:0] pages;
    logic       last;
  } fb_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [S_USER_W-1:0]   s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [M_USER_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data  = 1'b0;

  // shadow copy of the block state
  logic [7:0]           shadow_fb [0:STORE_BYTES-1];
  logic [NUM_PAGES-1:0] shadow_dirty = '0;
  logic                 shadow_blank = 1'b0;

  fb_result_t  awaited_out[$];
  int          fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned src_idle_pct  = 10;
  int unsigned sink_idle_pct = 85;
  logic        sink_hold     = 1'b0;

  paged_framebuffer_dirty_flush u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    fb_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_out.size() == 0) begin
        $error("result transfer with nothing expected: tdata %0h tuser %0h",
               m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = awaited_out.pop_front();
        compare_field("out_kind", want.kind, m_axis_tuser[0]);
        compare_field("read_byte", want.data, m_axis_tdata[7:0]);
        compare_field("run_start_page", want.start, m_axis_tdata[10:8]);
        compare_field("run_pages", want.pages, m_axis_tdata[14:11]);
        compare_field("last", want.last, m_axis_tlast);
      end
    end
  end

  function automatic void shadow_pixel(int px, int py, logic on);
    int pg;
    if (px < 0 || px >= SCREEN_WIDTH || py < 0 || py >= SCREEN_HEIGHT) return;
    pg = py / PAGE_ROWS;
    shadow_fb[pg * SCREEN_WIDTH + px][py % PAGE_ROWS] = on;
    shadow_dirty[pg] = 1'b1;
  endfunction

  // applies one accepted command and queues the results it must produce
  function automatic void shadow_execute(fb_cmd_t c);
    int x, y, wv, hv, x0, y0, x1, y1, i, j, pg, q, n, k;
    int run_first [RUN_LIMIT];
    int run_len [RUN_LIMIT];
    logic [NUM_PAGES-1:0] cleared;
    fb_result_t r;
    x  = $signed(c.x);
    y  = $signed(c.y);
    wv = c.w;
    hv = c.h;
    case (c.op)
      CMD_PIXEL: shadow_pixel(x, y, c.on);
      CMD_FILL: begin
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = (x + wv > SCREEN_WIDTH) ? SCREEN_WIDTH : x + wv;
        y1 = (y + hv > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + hv;
        for (j = y0; j < y1; j++)
          for (i = x0; i < x1; i++)
            shadow_pixel(i, j, c.on);
      end
      CMD_CLEAR: begin
        for (i = 0; i < STORE_BYTES; i++) shadow_fb[i] = '0;
        shadow_dirty = '1;
      end
      CMD_FLUSH: begin
        if (shadow_dirty != '0 && !shadow_blank) begin
          pg = 0;
          n = 0;
          cleared = '0;
          while (pg < NUM_PAGES && n < RUN_LIMIT) begin
            if (!shadow_dirty[pg]) begin
              pg++;
            end else begin
              q = pg;
              while (q < NUM_PAGES && shadow_dirty[q]) begin
                cleared[q] = 1'b1;
                q++;
              end
              run_first[n] = pg;
              run_len[n] = q - pg;
              n++;
              pg = q;
            end
          end
          shadow_dirty = shadow_dirty & ~cleared;
          for (k = 0; k < n; k++) begin
            r.kind  = OUT_KIND_RUN;
            r.data  = '0;
            r.start = run_first[k];
            r.pages = run_len[k];
            r.last  = (k == n - 1);
            awaited_out.push_back(r);
          end
        end
      end
      CMD_READ: begin
        r.kind  = OUT_KIND_READ;
        r.data  = '0;
        if (c.rpage < NUM_PAGES && c.rcol < SCREEN_WIDTH)
          r.data = shadow_fb[c.rpage * SCREEN_WIDTH + c.rcol];
        r.start = '0;
        r.pages = '0;
        r.last  = 1'b1;
        awaited_out.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic fb_cmd_t mk_cmd(logic [2:0] op, int x, int y, int w, int h,
                                     logic on, int rpage, int rcol);
    fb_cmd_t c;
    c.op    = op;
    c.x     = x;
    c.y     = y;
    c.w     = w;
    c.h     = h;
    c.on    = on;
    c.rpage = rpage;
    c.rcol  = rcol;
    return c;
  endfunction

  function automatic fb_cmd_t random_cmd();
    fb_cmd_t c;
    int unsigned sel;
    c.x     = $urandom_range(383) - 128;
    c.y     = $urandom_range(255) - 128;
    c.w     = $urandom_range(255);
    c.h     = $urandom_range(127);
    c.on    = $urandom_range(1);
    c.rpage = $urandom_range(7);
    c.rcol  = $urandom_range(127);
    sel = $urandom_range(99);
    if (sel < 40) begin
      c.op = CMD_PIXEL;
      // mostly on or just around the screen
      if ($urandom_range(9) != 0) begin
        c.x = $urandom_range(SCREEN_WIDTH + 15) - 8;
        c.y = $urandom_range(SCREEN_HEIGHT + 15) - 8;
      end
    end else if (sel < 65) begin
      c.op = CMD_FILL;
      // a few big rectangles, the rest small since each byte takes a ram read and a write
      if ($urandom_range(29) != 0) begin
        c.x = $urandom_range(SCREEN_WIDTH + 15) - 8;
        c.y = $urandom_range(SCREEN_HEIGHT + 15) - 8;
        c.w = $urandom_range(20);
        c.h = $urandom_range(20);
      end
    end else if (sel < 67) begin
      c.op = CMD_CLEAR;
    end else if (sel < 82) begin
      c.op = CMD_FLUSH;
    end else if (sel < 97) begin
      c.op = CMD_READ;
    end else begin
      c.op = $urandom_range(CMD_MAX_CODE, CMD_READ + 1);
    end
    return c;
  endfunction

  task automatic send_cmd(input fb_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, c.rcol, c.rpage, c.on, c.h, c.w, c.y, c.x};
    s_axis_tuser  <= c.op;
    do @(posedge clk); while (!s_axis_tready);
    shadow_execute(c);
  endtask

  // no-result commands may still be running once the queue is empty
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_blanking(input logic val);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_blank = val;
  endtask

  task automatic test_pixel_clipping();
    send_cmd(mk_cmd(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_PIXEL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_PIXEL, -128, 0, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_PIXEL, 255, 0, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_PIXEL, 0, -128, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_PIXEL, 0, 127, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, NUM_PAGES - 1, SCREEN_WIDTH - 1));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
  endtask

  task automatic test_fill_clipping();
    send_cmd(mk_cmd(CMD_FILL, -4, -4, 12, 12, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_FILL, 255, 127, 255, 127, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_FILL, 5, 5, 0, 127, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_FILL, 5, 5, 255, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 3));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
    // nothing dirty any more
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
  endtask

  task automatic test_clear();
    send_cmd(mk_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0));
    send_cmd(mk_cmd(CMD_PIXEL, 20, 17, 0, 0, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 2, 20));
  endtask

  task automatic test_split_runs();
    int k;
    // every other page dirty gives the most runs one flush can report
    for (k = 0; k < NUM_PAGES; k += 2)
      send_cmd(mk_cmd(CMD_PIXEL, 1, k * PAGE_ROWS, 0, 0, 1'b0, 0, 0));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
  endtask

  task automatic test_blanking();
    write_blanking(1'b1);
    send_cmd(mk_cmd(CMD_FILL, 0, 0, 255, 127, 1'b1, 0, 0));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
    write_blanking(1'b0);
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 5, 99));
  endtask

  task automatic test_unknown_cmds();
    send_cmd(mk_cmd(CMD_READ + 1, 3, 3, 4, 4, 1'b1, 1, 1));
    send_cmd(mk_cmd(CMD_MAX_CODE, 3, 3, 4, 4, 1'b1, 1, 1));
    send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, 0, 3));
  endtask

  task automatic test_random_traffic(input int n_items);
    int k;
    for (k = 0; k < n_items; k++) send_cmd(random_cmd());
  endtask

  task automatic test_output_backpressure();
    int k;
    fork
      begin
        sink_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        sink_hold = 1'b0;
      end
    join_none
    send_cmd(mk_cmd(CMD_FILL, 30, 0, 3, SCREEN_HEIGHT, 1'b1, 0, 0));
    for (k = 0; k < 10; k++)
      send_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 1'b0, $urandom_range(7), $urandom_range(29, 33)));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, 0, 0, 1'b0, 0, 0));
  endtask

  initial begin
    int i;
    for (i = 0; i < STORE_BYTES; i++) shadow_fb[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 10;
    sink_idle_pct = 85;
    test_pixel_clipping();
    test_fill_clipping();
    test_clear();
    test_split_runs();
    test_blanking();
    test_unknown_cmds();
    test_random_traffic(60);

    src_idle_pct  = 85;
    sink_idle_pct = 10;
    write_blanking(1'b1);
    test_random_traffic(40);
    write_blanking(1'b0);
    test_random_traffic(45);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(85);
    test_output_backpressure();

    drain_block();
    if (fail_count == 0 && awaited_out.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pfb_pkg.sv
rtl/core/pfb_ram.sv
rtl/core/paged_framebuffer_dirty_flush.sv
rtl/core/pfb_checker.sv
tb/paged_framebuffer_dirty_flush_tb.sv
